/* rtl/quaternion_to_euler_defines.svh */
// Assertion macros for the RTL
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// condition in the same cycle
`define QTE_ASSERT_NOW(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// condition in the next cycle
`define QTE_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* rtl/qte_pkg.sv */
package qte_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES
                                                                : ATAN_TABLE_LEN;
   localparam int ISQ_N = 30;   // one result bit per cell, radicand up to 2^58
   localparam int CW = 36;      // CORDIC datapath width
   localparam int RW = 60;      // square root root/trial width

   typedef struct packed {
      logic signed [31:0] t0;
      logic signed [31:0] t1;
      logic signed [31:0] t3;
      logic signed [31:0] t4;
      logic signed [30:0] t2;
   } terms_type;

   // atan(2^-i), 2^32 = 2 pi
   function automatic logic [31:0] qte_atan(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] qte_sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/quaternion_to_euler.sv */
// Path to rsp_valid: product, terms, square, radicand, root cells, pre-rotate, CORDIC, output.
// Throughput: one beat per cycle while the skid entry is empty; set by the single-step cells
// of the square root chain and the three CORDIC lanes, each a register per step.
// A two-entry output (register plus skid) lets the chain run one beat past a stalled rsp.
// Reset (synchronous, active high) clears every valid bit; data registers are not reset.
module quaternion_to_euler
   import qte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_angle_x,
   output logic signed [15:0] rsp_angle_y,
   output logic signed [15:0] rsp_angle_z
);

`include "quaternion_to_euler_defines.svh"

   // pipeline stage map: product, terms, square, radicand, root cells, pre-rotate, CORDIC
   localparam int PIPE_LEN = 4 + ISQ_N + 1 + CORDIC_RUN;

   logic en;                            // whole chain advances together
   logic [PIPE_LEN-1:0] vld_ff;

   // ---- stage 1: products (Q2.30) ----
   logic signed [31:0] p_yy_ff, p_zz_ff, p_xy_ff, p_wz_ff, p_wy_ff;
   logic signed [31:0] p_xz_ff, p_yz_ff, p_wx_ff, p_xx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_yy_ff <= req_quat_y * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
         p_xy_ff <= req_quat_x * req_quat_y;
         p_wz_ff <= req_quat_w * req_quat_z;
         p_wy_ff <= req_quat_w * req_quat_y;
         p_xz_ff <= req_quat_x * req_quat_z;
         p_yz_ff <= req_quat_y * req_quat_z;
         p_wx_ff <= req_quat_w * req_quat_x;
         p_xx_ff <= req_quat_x * req_quat_x;
      end
   end

   // ---- stage 2: terms t0..t4 (Q3.29), saturate, clamp t2 to +-1 ----
   terms_type terms_ff, terms_in;
   logic signed [32:0] s_t0, s_t1, s_t2, s_t3, s_t4;
   localparam logic signed [32:0] ONE33 = 33'sh0_2000_0000;

   always_comb begin
      s_t0 = ONE33 - (33'(p_yy_ff) + 33'(p_zz_ff));
      s_t1 = 33'(p_xy_ff) + 33'(p_wz_ff);
      s_t2 = 33'(p_wy_ff) - 33'(p_xz_ff);
      s_t3 = 33'(p_yz_ff) + 33'(p_wx_ff);
      s_t4 = ONE33 - (33'(p_xx_ff) + 33'(p_yy_ff));
      terms_in.t0 = qte_sat32(s_t0);
      terms_in.t1 = qte_sat32(s_t1);
      terms_in.t3 = qte_sat32(s_t3);
      terms_in.t4 = qte_sat32(s_t4);
      if (s_t2 > ONE33) terms_in.t2 = 31'sh2000_0000;
      else if (s_t2 < -ONE33) terms_in.t2 = -31'sh2000_0000;
      else terms_in.t2 = s_t2[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) terms_ff <= terms_in;
   end

   // terms ride alongside the square root chain
   terms_type td_ff [ISQ_N+2];

   always_ff @(posedge clock) begin
      if (en) begin
         td_ff[0] <= terms_ff;
         for (int j = 1; j < ISQ_N + 2; j++) td_ff[j] <= td_ff[j-1];
      end
   end

   // ---- stage 3: t2 squared (Q58), stage 4: radicand 1 - t2^2 ----
   logic signed [61:0] sq_full;
   logic [58:0] sq_ff, rad_ff;

   assign sq_full = terms_ff.t2 * terms_ff.t2;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_full[58:0];
         rad_ff <= (59'(1) << 58) - sq_ff;
      end
   end

   // ---- square root chain: one root bit per cell, weight 4^29 down to 4^0 ----
   logic [58:0]   rem_w  [ISQ_N+1];
   logic [RW-1:0] root_w [ISQ_N+1];

   assign rem_w[0] = rad_ff;
   assign root_w[0] = '0;

   for (genvar i = 0; i < ISQ_N; i++) begin : g_isq
      qte_isqrt_cell u_cell (
         .clock  (clock),
         .en     (en),
         .k      (5'(ISQ_N - 1 - i)),
         .rem_i  (rem_w[i]),
         .root_i (root_w[i]),
         .rem_o  (rem_w[i+1]),
         .root_o (root_w[i+1])
      );
   end

   // ---- pre-rotate: fold left half plane, flag zero vectors ----
   // lane 0: asin (t2, root), lane 1: (t3, t4), lane 2: (t1, t0)
   logic signed [CW-1:0] vx [3];
   logic signed [CW-1:0] vy [3];
   logic signed [CW-1:0] cx_w [3][CORDIC_RUN+1];
   logic signed [CW-1:0] cy_w [3][CORDIC_RUN+1];
   logic [31:0]          cz_w [3][CORDIC_RUN+1];
   logic signed [CW-1:0] px_ff [3];
   logic signed [CW-1:0] py_ff [3];
   logic [31:0]          pz_ff [3];
   logic [2:0]           zero_in;
   logic [2:0]           zd_ff [CORDIC_RUN+1];

   always_comb begin
      vx[0] = CW'($signed({1'b0, root_w[ISQ_N][29:0]}));
      vy[0] = CW'(td_ff[ISQ_N+1].t2);
      vx[1] = CW'(td_ff[ISQ_N+1].t4);
      vy[1] = CW'(td_ff[ISQ_N+1].t3);
      vx[2] = CW'(td_ff[ISQ_N+1].t0);
      vy[2] = CW'(td_ff[ISQ_N+1].t1);
      for (int l = 0; l < 3; l++) zero_in[l] = (vx[l] == '0) && (vy[l] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            if (vx[l][CW-1]) begin
               px_ff[l] <= -vx[l];
               py_ff[l] <= -vy[l];
               pz_ff[l] <= 32'h8000_0000;
            end else begin
               px_ff[l] <= vx[l];
               py_ff[l] <= vy[l];
               pz_ff[l] <= '0;
            end
         end
         zd_ff[0] <= zero_in;
         for (int j = 1; j < CORDIC_RUN + 1; j++) zd_ff[j] <= zd_ff[j-1];
      end
   end

   // ---- CORDIC lanes, vectoring mode ----
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign cx_w[l][0] = px_ff[l];
      assign cy_w[l][0] = py_ff[l];
      assign cz_w[l][0] = pz_ff[l];
      for (genvar s = 0; s < CORDIC_RUN; s++) begin : g_stg
         qte_cordic_cell u_cell (
            .clock (clock),
            .en    (en),
            .idx   (5'(s)),
            .x_i   (cx_w[l][s]),
            .y_i   (cy_w[l][s]),
            .z_i   (cz_w[l][s]),
            .x_o   (cx_w[l][s+1]),
            .y_o   (cy_w[l][s+1]),
            .z_o   (cz_w[l][s+1])
         );
      end
   end

   // ---- round to 16-bit binary angles ----
   // zero flag tap lines up with the last CORDIC cell output
   logic [31:0]        zr [3];
   logic signed [15:0] ang [3];
   logic signed [15:0] ax_clamped;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         zr[l] = cz_w[l][CORDIC_RUN] + 32'h0000_8000;
         ang[l] = zd_ff[CORDIC_RUN][l] ? 16'sd0 : $signed(zr[l][31:16]);
      end
      if (ang[0] > 16'sd16384) ax_clamped = 16'sd16384;
      else if (ang[0] < -16'sd16384) ax_clamped = -16'sd16384;
      else ax_clamped = ang[0];
   end

   // ---- valid line ----
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[PIPE_LEN-2:0], req_valid};
   end

   // ---- output register plus skid entry ----
   logic               out_v_ff, skid_v_ff;
   logic signed [15:0] out_ax_ff, out_ay_ff, out_az_ff;
   logic signed [15:0] sk_ax_ff, sk_ay_ff, sk_az_ff;
   logic               incoming, out_free;

   assign en = !skid_v_ff;
   assign incoming = en && vld_ff[PIPE_LEN-1];
   assign out_free = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_free) begin
            out_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
            out_ax_ff <= sk_ax_ff;
            out_ay_ff <= sk_ay_ff;
            out_az_ff <= sk_az_ff;
         end
      end else if (out_free) begin
         out_v_ff <= incoming;
         out_ax_ff <= ax_clamped;
         out_ay_ff <= ang[1];
         out_az_ff <= ang[2];
      end else if (incoming) begin
         skid_v_ff <= 1'b1;
         sk_ax_ff <= ax_clamped;
         sk_ay_ff <= ang[1];
         sk_az_ff <= ang[2];
      end
   end

   assign req_stall = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_angle_x = out_ax_ff;
   assign rsp_angle_y = out_ay_ff;
   assign rsp_angle_z = out_az_ff;

   // ---- checks ----
   logic ax_in_range;

   assign ax_in_range = (rsp_angle_x <= 16'sd16384) && (rsp_angle_x >= -16'sd16384);

   `QTE_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff, "skid full, output empty")
   `QTE_ASSERT_NOW(a_pitch_range, clock, reset, rsp_valid, ax_in_range, "angle_x out of range")
   `QTE_ASSERT_NEXT(a_skid_drains, clock, reset, skid_v_ff && !rsp_stall,
                    !skid_v_ff && out_v_ff, "skid did not drain")

endmodule

/* rtl/qte_isqrt_cell.sv */
module qte_isqrt_cell
   import qte_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  logic [4:0]    k,       // this cell tests bit weight 4^k
   input  logic [58:0]   rem_i,
   input  logic [RW-1:0] root_i,
   output logic [58:0]   rem_o,
   output logic [RW-1:0] root_o
);

   logic [58:0]   rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW-1:0] bb, trial;

   always_comb begin
      bb = RW'(1) << {k, 1'b0};
      trial = root_i + bb;
      if ({1'b0, rem_i} >= trial) begin
         rem_in = rem_i - trial[58:0];
         root_in = (root_i >> 1) + bb;
      end else begin
         rem_in = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o = rem_ff;
   assign root_o = root_ff;

endmodule

/* rtl/qte_cordic_cell.sv */
module qte_cordic_cell
   import qte_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [4:0]           idx,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic [31:0]          z_i,
   output logic signed [CW-1:0] x_o,
   output logic signed [CW-1:0] y_o,
   output logic [31:0]          z_o
);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic [31:0]          z_ff, z_in;

   always_comb begin
      xs = x_i >>> idx;
      ys = y_i >>> idx;
      if (!y_i[CW-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + qte_atan(idx);
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - qte_atan(idx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule
